// ===== src/phase_slope_delay_estimator_unit_defines.svh =====
// Assertion macros shared by the phase-slope delay estimator RTL.
`ifndef PHASE_SLOPE_DELAY_ESTIMATOR_UNIT_DEFINES_SVH
`define PHASE_SLOPE_DELAY_ESTIMATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PSDE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("phase slope delay estimator: check failed");
`define PSDE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("phase slope delay estimator: sequence check failed");
`else
`define PSDE_ASSERT(lbl, clk, rst, prop)
`define PSDE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/psde_pkg.sv =====
// Shared widths, constants and types of the phase-slope delay estimator.
package psde_pkg;

  localparam int W_FREQ      = 24;
  localparam int W_PHASE     = 16;
  localparam int W_CNT       = 13;
  localparam int MAX_POINTS  = 4096;
  localparam int MIN_FIT     = 3;
  localparam int W_OFF       = 14;
  localparam int W_UNW       = 31;
  localparam int W_UMAG      = 29;
  localparam int W_SF        = 37;
  localparam int W_SP        = 42;
  localparam int W_SFP       = 64;
  localparam int W_SFQ       = 60;
  localparam int W_LIMB      = 32;
  localparam int W_PROD      = 64;
  localparam int W_ACC       = 128;
  localparam int W_ANUM      = 80;
  localparam int W_ADEN      = 73;
  localparam int W_DIVN      = 113;
  localparam int W_DIVD      = 89;
  localparam int W_QUO       = 47;
  localparam int W_DELAY     = 48;
  localparam int W_STATUS    = 2;
  localparam int W_IN_TDATA  = 40;
  localparam int W_OUT_TDATA = 56;
  localparam int W_STEP      = 4;

  // pi/90 scaled by 2^36: slope in phase/freq units to delay in 2^-20 s
  localparam logic [W_LIMB-1:0] DELAY_K = 32'd2398762259;
  localparam logic signed [W_PHASE:0] HALF_TURN = 17'sd23040;

  // fit status codes
  localparam logic [W_STATUS-1:0] FIT_OK       = 2'd0;
  localparam logic [W_STATUS-1:0] FIT_FEW      = 2'd1;
  localparam logic [W_STATUS-1:0] FIT_SINGULAR = 2'd2;

  // configuration register indexes
  localparam logic CFG_BAND_LOW  = 1'b0;
  localparam logic CFG_BAND_HIGH = 1'b1;

  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_LOAD,
    MAC_ACC
  } mac_op_t;

  typedef struct packed {
    mac_op_t    op;
    logic       sub;
    logic [1:0] shift;
  } mac_cmd_t;

endpackage

// ===== src/phase_slope_delay_estimator_unit.sv =====
// Top level of the phase-slope delay estimator: point intake, sums and fit sequencer.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------------------------
//  s_axis   | s_axis_tvalid / s_axis_tready | tdata: ang_freq, phase_value; tlast: last
//  m_axis   | m_axis_tvalid / m_axis_tready | tdata: delay_estimate, fit_status
//  cfg      | cfg_valid / cfg_ready         | cfg_index, cfg_data (band bounds)
//
// An in-band point, while fewer than 4096 are held, is accepted and then makes two passes
// through the shared 32x32 multiplier; any other point is only accepted.
// A last point adds the fit: 15 limb products on the same multiplier, then the
// 113-step restoring divider.
// Reset is synchronous; the band opens to the full frequency range.
// The result register holds until taken; a later result waits for it to drain.
module phase_slope_delay_estimator_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [23:0] ang_freq, [39:24] phase_value
  input  logic [psde_pkg::W_IN_TDATA-1:0]  s_axis_tdata,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [47:0] delay_estimate, [49:48] fit_status, [55:50] zero
  output logic [psde_pkg::W_OUT_TDATA-1:0] m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [psde_pkg::W_FREQ-1:0]      cfg_data
);
  import psde_pkg::*;
  `include "phase_slope_delay_estimator_unit_defines.svh"

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_WP,
    ST_MUL_WW,
    ST_CHECK,
    ST_NUM,
    ST_NUM_ABS,
    ST_DEN,
    ST_DEN_ABS,
    ST_SCALE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_RESULT
  } state_t;

  localparam logic [W_STEP-1:0] STEP_NUM_END    = 4'd5;
  localparam logic [W_STEP-1:0] STEP_DEN_BEGIN  = 4'd6;
  localparam logic [W_STEP-1:0] STEP_DEN_END    = 4'd11;
  localparam logic [W_STEP-1:0] STEP_SCALE_BEGIN = 4'd12;
  localparam logic [W_STEP-1:0] STEP_SCALE_END  = 4'd14;

  state_t state;
  logic [W_STEP-1:0] step;

  logic [W_FREQ-1:0]  band_low;
  logic [W_FREQ-1:0]  band_high;
  logic               seen_first;
  logic [W_PHASE-1:0] prior_phase;
  logic [W_OFF-1:0]   turn_offset;
  logic [W_CNT-1:0]   point_count;
  logic [W_SF-1:0]    sum_freq;
  logic [W_SP-1:0]    sum_phase;
  logic [W_SFP-1:0]   sum_freq_phase;
  logic [W_SFQ-1:0]   sum_freq_sq;

  logic [W_FREQ-1:0]  w_reg;
  logic [W_UMAG-1:0]  u_mag;
  logic               u_neg;
  logic               last_reg;
  logic [W_SFP-1:0]   sfp_mag;
  logic               sfp_neg;
  logic [W_SP-1:0]    sp_mag;
  logic               sp_neg;
  logic [W_ANUM-1:0]  anum;
  logic               num_neg;
  logic [W_ADEN-1:0]  aden;
  logic               den_neg;
  logic [W_DELAY-1:0] res_delay;
  logic [W_STATUS-1:0] res_status;
  logic [W_DELAY-1:0] out_delay;
  logic [W_STATUS-1:0] out_status;
  logic               out_valid;

  // intake datapath
  logic [W_FREQ-1:0]  in_w;
  logic [W_PHASE-1:0] in_p;
  logic [W_PHASE-1:0] prev;
  logic signed [W_PHASE:0] diff;
  logic [W_OFF-1:0]   off_adj;
  logic [W_UNW-1:0]   off_ext;
  logic [W_UNW-1:0]   unw;
  logic [W_UNW-1:0]   unw_mag;
  logic               in_band;
  logic               take;
  logic               in_accept;

  // shared unit
  mac_cmd_t           mcmd;
  logic [W_LIMB-1:0]  op_a;
  logic [W_LIMB-1:0]  op_b;
  logic [W_ACC-1:0]   load_val;
  logic [W_PROD-1:0]  prod;
  logic [W_ACC-1:0]   mac_acc;
  logic [W_ACC-1:0]   acc_abs;

  // divider
  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [W_QUO-1:0]   div_quot;
  logic               div_big;
  logic               fit_neg;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(W_OUT_TDATA-W_DELAY-W_STATUS){1'b0}}, out_status, out_delay};

  // unwrap the incoming phase by at most one turn
  always_comb begin
    in_w    = s_axis_tdata[W_FREQ-1:0];
    in_p    = s_axis_tdata[W_FREQ +: W_PHASE];
    prev    = seen_first ? prior_phase : in_p;
    diff    = $signed({in_p[W_PHASE-1], in_p}) - $signed({prev[W_PHASE-1], prev});
    if (diff > HALF_TURN) begin
      off_adj = turn_offset - W_OFF'(1);
    end else if (diff < -HALF_TURN) begin
      off_adj = turn_offset + W_OFF'(1);
    end else begin
      off_adj = turn_offset;
    end
    off_ext = {{(W_UNW-W_OFF){off_adj[W_OFF-1]}}, off_adj};
    // one turn is 46080 = 45 * 1024 phase units
    unw     = {{(W_UNW-W_PHASE){in_p[W_PHASE-1]}}, in_p} + (off_ext << 15)
              + (off_ext << 13) + (off_ext << 12) + (off_ext << 10);
    unw_mag = unw[W_UNW-1] ? (~unw + W_UNW'(1)) : unw;
    in_band = (in_w >= band_low) && (in_w <= band_high);
    take    = in_band && !point_count[W_CNT-1];
  end

  assign acc_abs = mac_acc[W_ACC-1] ? (~mac_acc + W_ACC'(1)) : mac_acc;

  // drive the shared multiplier and accumulator
  always_comb begin
    op_a     = '0;
    op_b     = '0;
    load_val = '0;
    mcmd     = '{op: MAC_HOLD, sub: 1'b0, shift: 2'd0};
    unique case (state)
      ST_MUL_WP: begin
        op_a = {{(W_LIMB-W_FREQ){1'b0}}, w_reg};
        op_b = {{(W_LIMB-W_UMAG){1'b0}}, u_mag};
      end
      ST_MUL_WW: begin
        op_a = {{(W_LIMB-W_FREQ){1'b0}}, w_reg};
        op_b = {{(W_LIMB-W_FREQ){1'b0}}, w_reg};
      end
      ST_CHECK, ST_NUM_ABS: begin
        mcmd.op = MAC_LOAD;
      end
      ST_DEN_ABS: begin
        mcmd.op  = MAC_LOAD;
        load_val = {{(W_ACC-W_ADEN-15){1'b0}}, acc_abs[W_ADEN-1:0], 15'b0};
      end
      ST_NUM, ST_DEN, ST_SCALE: begin
        mcmd.op = MAC_ACC;
        unique case (step)
          4'd0: begin
            op_a = {{(W_LIMB-W_CNT){1'b0}}, point_count};
            op_b = sfp_mag[31:0];
            mcmd.sub = sfp_neg;
          end
          4'd1: begin
            op_a = {{(W_LIMB-W_CNT){1'b0}}, point_count};
            op_b = sfp_mag[63:32];
            mcmd.sub = sfp_neg;
            mcmd.shift = 2'd1;
          end
          4'd2: begin
            op_a = sum_freq[31:0];
            op_b = sp_mag[31:0];
            mcmd.sub = !sp_neg;
          end
          4'd3: begin
            op_a = sum_freq[31:0];
            op_b = {{(2*W_LIMB-W_SP){1'b0}}, sp_mag[W_SP-1:32]};
            mcmd.sub = !sp_neg;
            mcmd.shift = 2'd1;
          end
          4'd4: begin
            op_a = {{(2*W_LIMB-W_SF){1'b0}}, sum_freq[W_SF-1:32]};
            op_b = sp_mag[31:0];
            mcmd.sub = !sp_neg;
            mcmd.shift = 2'd1;
          end
          4'd5: begin
            op_a = {{(2*W_LIMB-W_SF){1'b0}}, sum_freq[W_SF-1:32]};
            op_b = {{(2*W_LIMB-W_SP){1'b0}}, sp_mag[W_SP-1:32]};
            mcmd.sub = !sp_neg;
            mcmd.shift = 2'd2;
          end
          4'd6: begin
            op_a = {{(W_LIMB-W_CNT){1'b0}}, point_count};
            op_b = sum_freq_sq[31:0];
          end
          4'd7: begin
            op_a = {{(W_LIMB-W_CNT){1'b0}}, point_count};
            op_b = {{(2*W_LIMB-W_SFQ){1'b0}}, sum_freq_sq[W_SFQ-1:32]};
            mcmd.shift = 2'd1;
          end
          4'd8: begin
            op_a = sum_freq[31:0];
            op_b = sum_freq[31:0];
            mcmd.sub = 1'b1;
          end
          4'd9: begin
            op_a = sum_freq[31:0];
            op_b = {{(2*W_LIMB-W_SF){1'b0}}, sum_freq[W_SF-1:32]};
            mcmd.sub = 1'b1;
            mcmd.shift = 2'd1;
          end
          4'd10: begin
            op_a = {{(2*W_LIMB-W_SF){1'b0}}, sum_freq[W_SF-1:32]};
            op_b = sum_freq[31:0];
            mcmd.sub = 1'b1;
            mcmd.shift = 2'd1;
          end
          4'd11: begin
            op_a = {{(2*W_LIMB-W_SF){1'b0}}, sum_freq[W_SF-1:32]};
            op_b = {{(2*W_LIMB-W_SF){1'b0}}, sum_freq[W_SF-1:32]};
            mcmd.sub = 1'b1;
            mcmd.shift = 2'd2;
          end
          4'd12: begin
            op_a = anum[31:0];
            op_b = DELAY_K;
          end
          4'd13: begin
            op_a = anum[63:32];
            op_b = DELAY_K;
            mcmd.shift = 2'd1;
          end
          4'd14: begin
            op_a = {{(3*W_LIMB-W_ANUM){1'b0}}, anum[W_ANUM-1:64]};
            op_b = DELAY_K;
            mcmd.shift = 2'd2;
          end
          default: begin
            mcmd.op = MAC_HOLD;
          end
        endcase
      end
      default: begin
        mcmd.op = MAC_HOLD;
      end
    endcase
  end

  assign div_start = (state == ST_DIV_GO);
  assign fit_neg   = num_neg ^ den_neg;

  psde_mac u_mac (
    .clk      (clk),
    .cmd      (mcmd),
    .op_a     (op_a),
    .op_b     (op_b),
    .load_val (load_val),
    .prod     (prod),
    .acc      (mac_acc)
  );

  psde_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (mac_acc[W_DIVN-1:0]),
    .denom ({aden, 16'b0}),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot),
    .big   (div_big)
  );

  // sequencer, sums and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      step           <= '0;
      band_low       <= '0;
      band_high      <= '1;
      seen_first     <= 1'b0;
      prior_phase    <= '0;
      turn_offset    <= '0;
      point_count    <= '0;
      sum_freq       <= '0;
      sum_phase      <= '0;
      sum_freq_phase <= '0;
      sum_freq_sq    <= '0;
      out_valid      <= 1'b0;
    end else begin
      // take band bounds
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_BAND_LOW:  band_low  <= cfg_data;
          CFG_BAND_HIGH: band_high <= cfg_data;
          default:       band_low  <= band_low;
        endcase
      end

      // drop the result once taken, unless a new one replaces it
      if (out_valid && m_axis_tready && (state != ST_RESULT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            seen_first <= 1'b1;
            last_reg   <= s_axis_tlast;
            if (!seen_first || in_band) begin
              prior_phase <= in_p;
            end
            if (in_band) begin
              turn_offset <= off_adj;
            end
            if (take) begin
              point_count <= point_count + W_CNT'(1);
              sum_freq    <= sum_freq + {{(W_SF-W_FREQ){1'b0}}, in_w};
              sum_phase   <= sum_phase + {{(W_SP-W_UNW){unw[W_UNW-1]}}, unw};
              w_reg       <= in_w;
              u_mag       <= unw_mag[W_UMAG-1:0];
              u_neg       <= unw[W_UNW-1];
              state       <= ST_MUL_WP;
            end else if (s_axis_tlast) begin
              state <= ST_CHECK;
            end
          end
        end
        ST_MUL_WP: begin
          sum_freq_phase <= u_neg ? (sum_freq_phase - prod) : (sum_freq_phase + prod);
          state          <= ST_MUL_WW;
        end
        ST_MUL_WW: begin
          sum_freq_sq <= sum_freq_sq + prod[W_SFQ-1:0];
          state       <= last_reg ? ST_CHECK : ST_IDLE;
        end
        ST_CHECK: begin
          sfp_neg <= sum_freq_phase[W_SFP-1];
          sfp_mag <= sum_freq_phase[W_SFP-1] ? (~sum_freq_phase + W_SFP'(1)) : sum_freq_phase;
          sp_neg  <= sum_phase[W_SP-1];
          sp_mag  <= sum_phase[W_SP-1] ? (~sum_phase + W_SP'(1)) : sum_phase;
          step    <= '0;
          if (point_count < W_CNT'(MIN_FIT)) begin
            res_status <= FIT_FEW;
            res_delay  <= '0;
            state      <= ST_RESULT;
          end else begin
            state <= ST_NUM;
          end
        end
        ST_NUM: begin
          step <= step + W_STEP'(1);
          if (step == STEP_NUM_END) begin
            state <= ST_NUM_ABS;
          end
        end
        ST_NUM_ABS: begin
          anum    <= acc_abs[W_ANUM-1:0];
          num_neg <= mac_acc[W_ACC-1];
          step    <= STEP_DEN_BEGIN;
          state   <= ST_DEN;
        end
        ST_DEN: begin
          step <= step + W_STEP'(1);
          if (step == STEP_DEN_END) begin
            state <= ST_DEN_ABS;
          end
        end
        ST_DEN_ABS: begin
          if (mac_acc == '0) begin
            res_status <= FIT_SINGULAR;
            res_delay  <= '0;
            state      <= ST_RESULT;
          end else begin
            aden    <= acc_abs[W_ADEN-1:0];
            den_neg <= mac_acc[W_ACC-1];
            step    <= STEP_SCALE_BEGIN;
            state   <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          step <= step + W_STEP'(1);
          if (step == STEP_SCALE_END) begin
            state <= ST_DIV_GO;
          end
        end
        ST_DIV_GO: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            res_status <= FIT_OK;
            // negate a positive slope, saturate to the 48-bit range
            if (!fit_neg) begin
              res_delay <= div_big ? {1'b1, {(W_DELAY-1){1'b0}}}
                                   : (~{1'b0, div_quot} + W_DELAY'(1));
            end else begin
              res_delay <= div_big ? {1'b0, {(W_DELAY-1){1'b1}}} : {1'b0, div_quot};
            end
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!out_valid || m_axis_tready) begin
            out_valid      <= 1'b1;
            out_delay      <= res_delay;
            out_status     <= res_status;
            seen_first     <= 1'b0;
            prior_phase    <= '0;
            turn_offset    <= '0;
            point_count    <= '0;
            sum_freq       <= '0;
            sum_phase      <= '0;
            sum_freq_phase <= '0;
            sum_freq_sq    <= '0;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `PSDE_ASSERT(a_count_capped, clk, rst, point_count <= W_CNT'(MAX_POINTS))
  `PSDE_ASSERT(a_den_nonneg, clk, rst, (state == ST_DEN_ABS) |-> !mac_acc[W_ACC-1])
  `PSDE_ASSERT(a_error_zero_delay, clk, rst, (out_valid && (out_status != FIT_OK)) |-> (out_delay == '0))
  `PSDE_ASSERT(a_div_only_in_fit, clk, rst, div_busy |-> (state == ST_DIV_WAIT))
  `PSDE_ASSERT_NEXT(a_result_clears, clk, rst, (state == ST_RESULT) && (!out_valid || m_axis_tready), out_valid && (point_count == '0) && !seen_first)

endmodule

// ===== src/psde_mac.sv =====
// Shared 32x32 multiplier with a 128-bit limb-shifted add/subtract accumulator.
module psde_mac (
  input  logic                       clk,
  input  psde_pkg::mac_cmd_t         cmd,
  input  logic [psde_pkg::W_LIMB-1:0] op_a,
  input  logic [psde_pkg::W_LIMB-1:0] op_b,
  input  logic [psde_pkg::W_ACC-1:0]  load_val,
  output logic [psde_pkg::W_PROD-1:0] prod,
  output logic [psde_pkg::W_ACC-1:0]  acc
);
  import psde_pkg::*;

  logic [W_ACC-1:0] term;
  logic [W_ACC-1:0] addend;

  // multiply one limb pair
  assign prod = op_a * op_b;

  // place the product at its limb and pick the sign
  always_comb begin
    term   = {{(W_ACC-W_PROD){1'b0}}, prod} << {cmd.shift, 5'b0};
    addend = cmd.sub ? (~term + W_ACC'(1)) : term;
  end

  // load or accumulate
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      MAC_LOAD: acc <= load_val;
      MAC_ACC:  acc <= acc + addend;
      default:  acc <= acc;
    endcase
  end

endmodule

// ===== src/psde_div.sv =====
// Restoring divider, one quotient bit per cycle, with quotient saturation flag.
module psde_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [psde_pkg::W_DIVN-1:0] numer,
  input  logic [psde_pkg::W_DIVD-1:0] denom,
  output logic                        busy,
  output logic                        done,
  output logic [psde_pkg::W_QUO-1:0]  quot,
  output logic                        big
);
  import psde_pkg::*;
  `include "phase_slope_delay_estimator_unit_defines.svh"

  localparam int W_DCNT = $clog2(W_DIVN);

  logic [W_DIVN-1:0] nsh;
  logic [W_DIVD-1:0] rem;
  logic [W_DIVD-1:0] dsr;
  logic [W_DCNT-1:0] cnt;
  logic [W_DIVD:0]   trial;
  logic [W_DIVD:0]   diff;
  logic              fits;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, nsh[W_DIVN-1]};
    diff  = trial - {1'b0, dsr};
    fits  = trial >= {1'b0, dsr};
  end

  // sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= W_DCNT'(W_DIVN - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - W_DCNT'(1);
        end
      end
    end
  end

  // shift numerator bits in, quotient bits out
  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= numer;
      dsr  <= denom;
      rem  <= '0;
      quot <= '0;
      big  <= 1'b0;
    end else if (busy) begin
      nsh  <= nsh << 1;
      rem  <= fits ? diff[W_DIVD-1:0] : trial[W_DIVD-1:0];
      quot <= {quot[W_QUO-2:0], fits};
      big  <= big | quot[W_QUO-1];
    end
  end

  `PSDE_ASSERT(a_rem_below_divisor, clk, rst, busy |-> (rem < dsr))
  `PSDE_ASSERT(a_start_when_free, clk, rst, start |-> !busy)
  `PSDE_ASSERT_NEXT(a_done_single, clk, rst, done, !done && !busy)

endmodule
